/* src/bitr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bitr_pkg;

  localparam logic [4:0] RADIX_LO       = 5'd2;
  localparam logic [4:0] RADIX_HI       = 5'd16;
  localparam logic [3:0] DECIMAL_DIGITS = 4'd10;
  localparam logic [6:0] CHAR_ZERO      = 7'h30;
  localparam logic [6:0] CHAR_A         = 7'h41;
  localparam int         DIV_STEP       = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } back_state_e;

  typedef struct packed {
    logic       bad;
    logic [4:0] radix;
  } cls_t;

  typedef struct packed {
    logic [3:0] value;
    logic       last;
    logic       bad;
  } out_word_t;

  function automatic logic [6:0] digit_ascii(input logic [3:0] d);
    if (d < DECIMAL_DIGITS) begin
      return CHAR_ZERO + 7'(d);
    end else begin
      return CHAR_A + 7'(d - DECIMAL_DIGITS);
    end
  endfunction

endpackage

`default_nettype wire

/* src/bitr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module bitr_front #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic [4:0]             radix_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0]      out_value_o,
  output bitr_pkg::cls_t              out_cls_o
);
  import bitr_pkg::*;

  logic [VALUE_WIDTH-1:0] val_q [2];
  cls_t                   cls_q [2];
  logic                   wptr_q, wptr_d;
  logic                   rptr_q, rptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   wr_en, rd_en;
  cls_t                   cls_new;

  assign full        = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign wr_en       = push && !full;
  assign rd_en       = out_valid_o && out_ready_i;
  assign out_value_o = val_q[rptr_q];
  assign out_cls_o   = cls_q[rptr_q];

  always_comb begin
    cls_new.radix = radix_i;
    cls_new.bad   = (radix_i < RADIX_LO) || (radix_i > RADIX_HI);
    wptr_d        = wptr_q ^ wr_en;
    rptr_d        = rptr_q ^ rd_en;
    cnt_d         = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      val_q[wptr_q] <= value_i;
      cls_q[wptr_q] <= cls_new;
    end
  end

endmodule

`default_nettype wire

/* src/bitr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module bitr_back #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0] in_value_i,
  input  wire bitr_pkg::cls_t         in_cls_i,
  input  wire logic                   pop,
  output logic                        empty,
  output bitr_pkg::out_word_t         word_o
);
  import bitr_pkg::*;

  localparam int NCHUNK = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W  = NCHUNK * DIV_STEP;
  localparam int CHW    = $clog2(NCHUNK + 1);
  localparam int AW     = $clog2(VALUE_WIDTH);
  localparam int SPW    = $clog2(VALUE_WIDTH + 1);

  back_state_e      state_q, state_d;
  logic [PAD_W-1:0] work_q, work_d;
  logic [3:0]       rem_q, rem_d;
  logic [4:0]       radix_q, radix_d;
  logic [CHW-1:0]   chunk_q, chunk_d;
  logic [SPW-1:0]   sp_q, sp_d;
  logic [SPW-1:0]   sp_m1;
  logic             inflight_q, inflight_d;
  logic             last_q, last_d;

  logic [PAD_W-1:0] step_work;
  logic [4:0]       step_rem;

  logic [3:0]       digit_mem [VALUE_WIDTH];
  logic [3:0]       mem_rd_q;
  logic             mem_we, mem_re;

  out_word_t        ow_q [2];
  out_word_t        ow_new;
  logic             owp_q, owp_d;
  logic             orp_q, orp_d;
  logic [1:0]       ocnt_q, ocnt_d;
  logic             ow_we, err_push, pop_ok, room;

  assign empty  = (ocnt_q == 2'd0);
  assign word_o = ow_q[orp_q];
  assign pop_ok = pop && !empty;
  assign room   = ({1'b0, ocnt_q} + {2'b00, inflight_q}) < (3'd2 + {2'b00, pop_ok});
  assign sp_m1  = sp_q - SPW'(1);

  always_comb begin
    step_rem  = {1'b0, rem_q};
    step_work = work_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      step_rem  = {step_rem[3:0], step_work[PAD_W-1]};
      step_work = {step_work[PAD_W-2:0], 1'b0};
      if (step_rem >= radix_q) begin
        step_rem     = step_rem - radix_q;
        step_work[0] = 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    work_d     = work_q;
    rem_d      = rem_q;
    radix_d    = radix_q;
    chunk_d    = chunk_q;
    sp_d       = sp_q;
    last_d     = last_q;
    inflight_d = 1'b0;
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    err_push   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          radix_d = in_cls_i.radix;
          work_d  = PAD_W'(in_value_i);
          rem_d   = 4'd0;
          chunk_d = CHW'(NCHUNK);
          sp_d    = '0;
          state_d = in_cls_i.bad ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        work_d  = step_work;
        rem_d   = step_rem[3:0];
        chunk_d = chunk_q - CHW'(1);
        if (chunk_q == CHW'(1)) begin
          mem_we  = 1'b1;
          sp_d    = sp_q + SPW'(1);
          rem_d   = 4'd0;
          chunk_d = CHW'(NCHUNK);
          if (step_work == '0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (room) begin
          mem_re     = 1'b1;
          inflight_d = 1'b1;
          last_d     = (sp_q == SPW'(1));
          sp_d       = sp_m1;
          if (sp_q == SPW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (room && !inflight_q) begin
          err_push = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ow_we = inflight_q || err_push;
    if (inflight_q) begin
      ow_new.value = mem_rd_q;
      ow_new.last  = last_q;
      ow_new.bad   = 1'b0;
    end else begin
      ow_new.value = 4'd0;
      ow_new.last  = 1'b1;
      ow_new.bad   = 1'b1;
    end
    owp_d  = owp_q ^ ow_we;
    orp_d  = orp_q ^ pop_ok;
    ocnt_d = ocnt_q + {1'b0, ow_we} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      chunk_q    <= '0;
      sp_q       <= '0;
      inflight_q <= 1'b0;
      last_q     <= 1'b0;
      owp_q      <= 1'b0;
      orp_q      <= 1'b0;
      ocnt_q     <= 2'd0;
    end else begin
      state_q    <= state_d;
      chunk_q    <= chunk_d;
      sp_q       <= sp_d;
      inflight_q <= inflight_d;
      last_q     <= last_d;
      owp_q      <= owp_d;
      orp_q      <= orp_d;
      ocnt_q     <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    if (ow_we) begin
      ow_q[owp_q] <= ow_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[sp_q[AW-1:0]] <= step_rem[3:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rd_q <= digit_mem[sp_m1[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

/* src/binary_to_radix_digits.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each item passes through the input queue, then the iterative divider, which retires eight
// quotient bits a cycle and stores each digit, then the digit memory, read back most significant
// digit first, into the output queue. The converter takes one item at a time: it accepts a new
// one only when it is idle again. Digits leave at one word per cycle while pop is held; a bad
// radix gives its single word through the input queue and the error state into the output queue.
// Reset is asynchronous, active low, and empties both queues and returns the converter to idle.

module binary_to_radix_digits #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic [4:0]             radix_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [6:0]                  digit_char_o,
  output logic [3:0]                  digit_value_o,
  output logic                        last_digit_o,
  output logic                        bad_radix_o
);
  import bitr_pkg::*;

  logic                   q_valid, q_ready;
  logic [VALUE_WIDTH-1:0] q_value;
  cls_t                   q_cls;
  out_word_t              word;

  bitr_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .radix_i    (radix_i),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_value_o(q_value),
    .out_cls_o  (q_cls)
  );

  bitr_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(q_valid),
    .in_ready_o(q_ready),
    .in_value_i(q_value),
    .in_cls_i  (q_cls),
    .pop       (pop),
    .empty     (empty),
    .word_o    (word)
  );

  assign digit_value_o = word.value;
  assign last_digit_o  = word.last;
  assign bad_radix_o   = word.bad;
  assign digit_char_o  = word.bad ? 7'd0 : digit_ascii(word.value);

endmodule

`default_nettype wire

/* src/bitr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module bitr_checker #(
  parameter int VALUE_WIDTH = 31
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   push,
  input wire logic                   full,
  input wire logic [VALUE_WIDTH-1:0] value_i,
  input wire logic [4:0]             radix_i,
  input wire logic                   empty,
  input wire logic                   pop,
  input wire logic [6:0]             digit_char_o,
  input wire logic [3:0]             digit_value_o,
  input wire logic                   last_digit_o,
  input wire logic                   bad_radix_o
);

  logic [6:0] exp_char;
  logic       in_seen;

  assign exp_char = (digit_value_o < 4'd10) ? (7'h30 + 7'(digit_value_o))
                                            : (7'h37 + 7'(digit_value_o));
  assign in_seen  = push || (value_i != '0) || (radix_i != '0) || full;

  // An error word stands alone and carries no digit.
  a_bad_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_radix_o) |-> (last_digit_o && digit_char_o == 7'd0 && digit_value_o == 4'd0))
    else $error("error word carries a digit");

  // A digit word shows the character that matches its value.
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !bad_radix_o) |-> (digit_char_o == exp_char))
    else $error("digit character does not match digit value");

  // Once a run has started, the words up to its last one are all digits.
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_digit_o) |=> (empty || !bad_radix_o))
    else $error("error word inside a digit run");

  // A waiting word is held until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop && in_seen | !in_seen) |=>
      (!$past(!empty && !pop) || (!empty && $stable(digit_value_o) && $stable(last_digit_o)
       && $stable(bad_radix_o))))
    else $error("waiting word changed before it was taken");

endmodule

bind binary_to_radix_digits bitr_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_bitr_checker (.*);

`default_nettype wire

/* bench/binary_to_radix_digits_tb.sv */
`timescale 1ns / 1ps

module binary_to_radix_digits_tb;

  import bitr_pkg::*;

  localparam int VW          = 31;
  localparam int RAND_ITEMS  = 185;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [6:0] ch;
    logic [3:0] val;
    logic       last;
    logic       bad;
  } digit_word_t;

  typedef struct {
    logic [VW-1:0] value;
    logic [4:0]    radix;
    bit            typed;
    logic [6:0]    ch;
    logic [3:0]    val;
    logic          bad;
  } stim_row_t;

  localparam int ROWS = 25;

  stim_row_t directed_rows [0:ROWS-1] = '{
    '{31'd0,          5'd10, 1'b1, CHAR_ZERO,        4'd0,  1'b0},
    '{31'd0,          5'd2,  1'b1, CHAR_ZERO,        4'd0,  1'b0},
    '{31'd0,          5'd16, 1'b1, CHAR_ZERO,        4'd0,  1'b0},
    '{31'd1,          5'd2,  1'b1, CHAR_ZERO + 7'd1, 4'd1,  1'b0},
    '{31'd9,          5'd10, 1'b1, CHAR_ZERO + 7'd9, 4'd9,  1'b0},
    '{31'd10,         5'd16, 1'b1, CHAR_A,           4'd10, 1'b0},
    '{31'd15,         5'd16, 1'b1, CHAR_A + 7'd5,    4'd15, 1'b0},
    '{31'h7FFFFFFF,   5'd0,  1'b1, 7'd0,             4'd0,  1'b1},
    '{31'h7FFFFFFF,   5'd1,  1'b1, 7'd0,             4'd0,  1'b1},
    '{31'd0,          5'd17, 1'b1, 7'd0,             4'd0,  1'b1},
    '{31'd12345,      5'd31, 1'b1, 7'd0,             4'd0,  1'b1},
    '{31'h7FFFFFFF,   5'd2,  1'b0, 7'd0,             4'd0,  1'b0},
    '{31'h7FFFFFFF,   5'd16, 1'b0, 7'd0,             4'd0,  1'b0},
    '{31'h7FFFFFFF,   5'd10, 1'b0, 7'd0,             4'd0,  1'b0},
    '{31'h7FFFFFFF,   5'd3,  1'b0, 7'd0,             4'd0,  1'b0},
    '{31'h40000000,   5'd2,  1'b0, 7'd0,             4'd0,  1'b0},
    '{31'd16,         5'd16, 1'b0, 7'd0,             4'd0,  1'b0},
    '{31'd10,         5'd10, 1'b0, 7'd0,             4'd0,  1'b0},
    '{31'h55555555,   5'd8,  1'b0, 7'd0,             4'd0,  1'b0},
    '{31'h2AAAAAAA,   5'd5,  1'b0, 7'd0,             4'd0,  1'b0},
    '{31'd123456789,  5'd7,  1'b0, 7'd0,             4'd0,  1'b0},
    '{31'd999999,     5'd11, 1'b0, 7'd0,             4'd0,  1'b0},
    '{31'h0ABCDEF,    5'd13, 1'b0, 7'd0,             4'd0,  1'b0},
    '{31'd987654,     5'd14, 1'b0, 7'd0,             4'd0,  1'b0},
    '{31'd65535,      5'd15, 1'b0, 7'd0,             4'd0,  1'b0}
  };

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          push    = 1'b0;
  logic          full;
  logic [VW-1:0] value_i = '0;
  logic [4:0]    radix_i = '0;
  logic          empty;
  logic          pop     = 1'b0;
  logic [6:0]    digit_char_o;
  logic [3:0]    digit_value_o;
  logic          last_digit_o;
  logic          bad_radix_o;

  digit_word_t pending_digits[$];
  bit          steady        = 1'b0;
  int          mismatches    = 0;
  int          numbers_sent  = 0;
  int          words_seen    = 0;
  int          flags_seen    = 0;
  int          cycle_count   = 0;

  binary_to_radix_digits #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .empty        (empty),
    .pop          (pop),
    .digit_char_o (digit_char_o),
    .digit_value_o(digit_value_o),
    .last_digit_o (last_digit_o),
    .bad_radix_o  (bad_radix_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void predict_digits(logic [VW-1:0] num, logic [4:0] base);
    logic [3:0]      digs[$];
    longint unsigned n;
    digit_word_t     w;
    n = num;
    if (base < RADIX_LO || base > RADIX_HI) begin
      w = '{7'd0, 4'd0, 1'b1, 1'b1};
      pending_digits.push_back(w);
      return;
    end
    do begin
      digs.push_front(4'(n % base));
      n = n / base;
    end while (n != 0);
    foreach (digs[i]) begin
      w.val  = digs[i];
      w.ch   = (digs[i] < DECIMAL_DIGITS) ? CHAR_ZERO + 7'(digs[i])
                                          : CHAR_A + 7'(digs[i] - DECIMAL_DIGITS);
      w.last = (i == digs.size() - 1);
      w.bad  = 1'b0;
      pending_digits.push_back(w);
    end
  endfunction

  task automatic send_number(logic [VW-1:0] v, logic [4:0] r);
    while (!steady && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= v;
    radix_i <= r;
    do @(posedge clk_i); while (full);
    numbers_sent++;
  endtask

  always @(posedge clk_i) begin : result_side
    digit_word_t want;
    if (rst_ni && pop && !empty) begin
      words_seen++;
      if (bad_radix_o) begin
        flags_seen++;
      end
      if (pending_digits.size() == 0) begin
        $error("unexpected digit word: char %0h value %0d", digit_char_o, digit_value_o);
        mismatches++;
      end else begin
        want = pending_digits.pop_front();
        if (digit_char_o !== want.ch) begin
          $error("digit_char: expected %0h, got %0h", want.ch, digit_char_o);
          mismatches++;
        end
        if (digit_value_o !== want.val) begin
          $error("digit_value: expected %0d, got %0d", want.val, digit_value_o);
          mismatches++;
        end
        if (last_digit_o !== want.last) begin
          $error("last_digit: expected %0b, got %0b", want.last, last_digit_o);
          mismatches++;
        end
        if (bad_radix_o !== want.bad) begin
          $error("bad_radix: expected %0b, got %0b", want.bad, bad_radix_o);
          mismatches++;
        end
      end
    end
    pop <= steady || ($urandom_range(99) >= 29);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [VW-1:0] v;
    logic [4:0]    r;
    int            w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].value, directed_rows[i].radix);
      if (directed_rows[i].typed) begin
        pending_digits.push_back('{directed_rows[i].ch, directed_rows[i].val, 1'b1,
                                   directed_rows[i].bad});
      end else begin
        predict_digits(directed_rows[i].value, directed_rows[i].radix);
      end
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      steady = (i >= 70 && i < 130);
      w = $urandom_range(1, VW);
      v = VW'($urandom) & ((VW'(1) << w) - 1'b1);
      if (w == VW) begin
        v = VW'($urandom);
      end
      if ($urandom_range(19) == 0) begin
        v = '0;
      end
      if ($urandom_range(99) < 85) begin
        r = 5'($urandom_range(RADIX_LO, RADIX_HI));
      end else begin
        r = 5'($urandom_range(0, 31));
      end
      send_number(v, r);
      predict_digits(v, r);
    end
    steady = 1'b0;
    push <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers in radices 0 to 31 into %0d digit words.",
             numbers_sent, words_seen);
    $display("Out-of-range radix flags seen: %0d; field mismatches: %0d.",
             flags_seen, mismatches);
    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bitr_pkg.sv
src/bitr_front.sv
src/bitr_back.sv
src/binary_to_radix_digits.sv
src/bitr_checker.sv
bench/binary_to_radix_digits_tb.sv
